@@ design/gbn_pkg.sv @@
// Shared types, constants and helpers for the greedy box NMS block.
// Used by greedy_box_nms; depends on nothing else.
`default_nettype none
package gbn_pkg;

    // Reset value of the overlap threshold, Q1.15
    localparam logic [15:0] THR_RESET = 16'd14746;
    // Threshold scale: one in Q1.15 as a shift
    localparam int THR_SHIFT = 15;
    // Byte address of the threshold register
    localparam logic [1:0] ADDR_THR = 2'd0;

    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic [15:0] confidence;
        logic [7:0]  class_label;
        logic [7:0]  image_tag;
        logic        last_box;
    } t_box_in;

    typedef struct packed {
        logic [15:0] kept_left_x;
        logic [15:0] kept_top_y;
        logic [15:0] kept_right_x;
        logic [15:0] kept_bottom_y;
        logic [15:0] kept_confidence;
        logic [7:0]  kept_label;
        logic [7:0]  kept_image;
        logic        final_kept;
        logic        overflowed;
    } t_box_out;

    // One stored candidate with its precomputed area
    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic [15:0] score;
        logic [7:0]  label;
        logic [7:0]  image;
        logic [31:0] area;
    } t_entry;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RANK,
        S_RANK_PUT,
        S_SA_RD,
        S_SA_WT,
        S_SA_BOX,
        S_SB_RD,
        S_SB_WT,
        S_SB_BOX,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_E_RD,
        S_E_WT,
        S_E_BOX
    } t_state;

    // Clamped extent: hi - lo, or zero when hi <= lo
    function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
        span = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

endpackage
`default_nettype wire

@@ design/greedy_box_nms.sv @@
// Greedy non-maximum suppression over one set of candidate boxes.
// Depends on gbn_pkg for the item types, state codes and span helper.
`default_nettype none
// Usage:
//   Candidates enter on i_box when start is high and busy is low, one item
//   per cycle while loading. The item with last_box set closes the set.
//   Up to MAX_BOXES boxes are stored; later ones are dropped and every
//   result of that set carries overflowed.
//   After the last item the block is busy: a selection scan ranks the set
//   (one box memory read per cycle), then the pair walk runs one shared
//   multiplier over each live pair, skipping removed boxes, then kept boxes
//   go out in rank order on o_kept with o_strobe high for one cycle.
//   With threshold zero ranking and suppression are skipped and boxes leave
//   in arrival order. The set is closed before loading resumes. final_kept
//   marks the last result of the set.
//   The receiver cannot stall; results are not held.
//   Reset returns the block to loading with an empty set and the threshold
//   at its reset value. The APB port writes and reads the threshold.
module greedy_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire gbn_pkg::t_box_in   i_box,
    output logic                    o_strobe,
    output gbn_pkg::t_box_out       o_kept,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [1:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    gbn_pkg::t_state r_state, n_state;

    // Stores
    gbn_pkg::t_entry box_mem [MAX_BOXES];
    logic [IW-1:0]   rank_mem [MAX_BOXES];
    gbn_pkg::t_entry r_box_q;
    logic [IW-1:0]   r_rank_q;

    logic [15:0]          r_thr;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [MAX_BOXES-1:0] r_removed;
    logic [MAX_BOXES-1:0] r_ranked;
    logic [CW-1:0]        r_rm_cnt;
    logic [CW-1:0]        r_emit_cnt;

    // Sequencer counters and scan state
    logic [CW-1:0] r_i, r_j, r_p;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic          r_found;
    logic [15:0]   r_best;
    logic [IW-1:0] r_bidx;
    logic [IW-1:0] r_b;

    // Pair datapath
    gbn_pkg::t_entry r_a;
    logic [15:0]     r_iw, r_ih;
    logic [31:0]     r_area_b;
    logic [31:0]     r_inter;
    logic [48:0]     r_prod;

    logic          r_strobe;
    gbn_pkg::t_box_out r_out;

    logic          accept;
    logic          thr_zero;
    logic [IW-1:0] box_addr;
    logic [IW-1:0] rank_addr;
    logic [15:0]   mul_a;
    logic [32:0]   mul_b;
    logic [48:0]   mul_p;
    logic [32:0]   uni;
    logic [CW-1:0] kept_total;

    assign accept     = start && !busy;
    assign thr_zero   = (r_thr == 16'd0);
    assign mul_p      = 49'(mul_a) * 49'(mul_b);
    assign uni        = {1'b0, r_a.area} + {1'b0, r_area_b} - {1'b0, r_inter};
    assign kept_total = r_count - r_rm_cnt;
    assign pready     = 1'b1;
    assign prdata     = (paddr == gbn_pkg::ADDR_THR) ? {16'd0, r_thr} : 32'd0;
    assign o_strobe   = r_strobe;
    assign o_kept     = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::S_LOAD: begin
                if (accept && i_box.last_box) begin
                    n_state = thr_zero ? gbn_pkg::S_E_RD : gbn_pkg::S_RANK;
                end
            end
            gbn_pkg::S_RANK: begin
                if (r_j >= r_count && !r_pv) n_state = gbn_pkg::S_RANK_PUT;
            end
            gbn_pkg::S_RANK_PUT: begin
                n_state = (r_p + CNT_ONE >= r_count) ? gbn_pkg::S_SA_RD : gbn_pkg::S_RANK;
            end
            gbn_pkg::S_SA_RD: begin
                n_state = (r_i >= r_count) ? gbn_pkg::S_E_RD : gbn_pkg::S_SA_WT;
            end
            gbn_pkg::S_SA_WT: begin
                n_state = r_removed[r_rank_q] ? gbn_pkg::S_SA_RD : gbn_pkg::S_SA_BOX;
            end
            gbn_pkg::S_SA_BOX: n_state = gbn_pkg::S_SB_RD;
            gbn_pkg::S_SB_RD: begin
                n_state = (r_j >= r_count) ? gbn_pkg::S_SA_RD : gbn_pkg::S_SB_WT;
            end
            gbn_pkg::S_SB_WT: begin
                n_state = r_removed[r_rank_q] ? gbn_pkg::S_SB_RD : gbn_pkg::S_SB_BOX;
            end
            gbn_pkg::S_SB_BOX: n_state = gbn_pkg::S_MUL1;
            gbn_pkg::S_MUL1:   n_state = gbn_pkg::S_MUL2;
            gbn_pkg::S_MUL2:   n_state = gbn_pkg::S_CMP;
            gbn_pkg::S_CMP:    n_state = gbn_pkg::S_SB_RD;
            gbn_pkg::S_E_RD: begin
                if (r_i >= r_count) n_state = gbn_pkg::S_LOAD;
                else n_state = thr_zero ? gbn_pkg::S_E_BOX : gbn_pkg::S_E_WT;
            end
            gbn_pkg::S_E_WT: begin
                n_state = r_removed[r_rank_q] ? gbn_pkg::S_E_RD : gbn_pkg::S_E_BOX;
            end
            gbn_pkg::S_E_BOX: n_state = gbn_pkg::S_E_RD;
            default: n_state = gbn_pkg::S_LOAD;
        endcase
    end

    // Outputs of the sequencer: busy, memory addresses, multiplier operands
    always_comb begin
        busy      = (r_state != gbn_pkg::S_LOAD);
        box_addr  = r_rank_q;
        rank_addr = r_i[IW-1:0];
        mul_a     = 16'd0;
        mul_b     = 33'd0;
        unique case (r_state)
            gbn_pkg::S_LOAD: begin
                mul_a = gbn_pkg::span(i_box.left_x, i_box.right_x);
                mul_b = {17'd0, gbn_pkg::span(i_box.top_y, i_box.bottom_y)};
            end
            gbn_pkg::S_RANK:  box_addr = r_j[IW-1:0];
            gbn_pkg::S_SB_RD: rank_addr = r_j[IW-1:0];
            gbn_pkg::S_E_RD:  box_addr = r_i[IW-1:0];
            gbn_pkg::S_MUL1: begin
                mul_a = r_iw;
                mul_b = {17'd0, r_ih};
            end
            gbn_pkg::S_MUL2: begin
                mul_a = r_thr;
                mul_b = uni;
            end
            default: ;
        endcase
    end

    // Memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (r_state == gbn_pkg::S_LOAD && accept && r_count < CNT_MAX) begin
            box_mem[r_count[IW-1:0]] <= '{
                left_x:   i_box.left_x,
                top_y:    i_box.top_y,
                right_x:  i_box.right_x,
                bottom_y: i_box.bottom_y,
                score:    i_box.confidence,
                label:    i_box.class_label,
                image:    i_box.image_tag,
                area:     mul_p[31:0]
            };
        end
        r_box_q <= box_mem[box_addr];
        if (r_state == gbn_pkg::S_RANK_PUT) begin
            rank_mem[r_p[IW-1:0]] <= r_bidx;
        end
        r_rank_q <= rank_mem[rank_addr];
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            gbn_pkg::S_RANK: begin
                r_pidx <= r_j[IW-1:0];
                if (r_pv && !r_ranked[r_pidx] && (!r_found || r_box_q.score > r_best)) begin
                    r_best <= r_box_q.score;
                    r_bidx <= r_pidx;
                end
            end
            gbn_pkg::S_SA_BOX: r_a <= r_box_q;
            gbn_pkg::S_SB_WT:  r_b <= r_rank_q;
            gbn_pkg::S_SB_BOX: begin
                r_iw <= gbn_pkg::span(
                    (r_a.left_x > r_box_q.left_x) ? r_a.left_x : r_box_q.left_x,
                    (r_a.right_x < r_box_q.right_x) ? r_a.right_x : r_box_q.right_x);
                r_ih <= gbn_pkg::span(
                    (r_a.top_y > r_box_q.top_y) ? r_a.top_y : r_box_q.top_y,
                    (r_a.bottom_y < r_box_q.bottom_y) ? r_a.bottom_y : r_box_q.bottom_y);
                r_area_b <= r_box_q.area;
            end
            gbn_pkg::S_MUL1: r_inter <= mul_p[31:0];
            gbn_pkg::S_MUL2: r_prod <= mul_p;
            gbn_pkg::S_E_BOX: begin
                r_out <= '{
                    kept_left_x:     r_box_q.left_x,
                    kept_top_y:      r_box_q.top_y,
                    kept_right_x:    r_box_q.right_x,
                    kept_bottom_y:   r_box_q.bottom_y,
                    kept_confidence: r_box_q.score,
                    kept_label:      r_box_q.label,
                    kept_image:      r_box_q.image,
                    final_kept:      (r_emit_cnt + CNT_ONE == kept_total),
                    overflowed:      r_ovf
                };
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbn_pkg::S_LOAD;
            r_thr      <= gbn_pkg::THR_RESET;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_removed  <= '0;
            r_ranked   <= '0;
            r_rm_cnt   <= '0;
            r_emit_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_p        <= '0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == gbn_pkg::S_E_BOX);
            // Take threshold writes
            if (psel && penable && pwrite) r_thr <= pwdata[15:0];
            case (r_state)
                gbn_pkg::S_LOAD: begin
                    if (accept) begin
                        if (r_count < CNT_MAX) r_count <= r_count + CNT_ONE;
                        else r_ovf <= 1'b1;
                        r_i      <= '0;
                        r_j      <= '0;
                        r_p      <= '0;
                        r_pv     <= 1'b0;
                        r_found  <= 1'b0;
                        r_ranked <= '0;
                    end
                end
                gbn_pkg::S_RANK: begin
                    // Issue one score read per cycle, judge the previous one
                    if (r_j < r_count) begin
                        r_j  <= r_j + CNT_ONE;
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && !r_ranked[r_pidx] && (!r_found || r_box_q.score > r_best)) begin
                        r_found <= 1'b1;
                    end
                end
                gbn_pkg::S_RANK_PUT: begin
                    r_ranked[r_bidx] <= 1'b1;
                    r_p     <= r_p + CNT_ONE;
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_i     <= '0;
                end
                gbn_pkg::S_SA_RD: begin
                    if (r_i >= r_count) r_i <= '0;
                end
                gbn_pkg::S_SA_WT: begin
                    if (r_removed[r_rank_q]) r_i <= r_i + CNT_ONE;
                end
                gbn_pkg::S_SA_BOX: r_j <= r_i + CNT_ONE;
                gbn_pkg::S_SB_RD: begin
                    if (r_j >= r_count) r_i <= r_i + CNT_ONE;
                end
                gbn_pkg::S_SB_WT: begin
                    if (r_removed[r_rank_q]) r_j <= r_j + CNT_ONE;
                end
                gbn_pkg::S_CMP: begin
                    // Drop the later box when inter exceeds thr * union
                    if ({2'b00, r_inter, {gbn_pkg::THR_SHIFT{1'b0}}} > r_prod) begin
                        r_removed[r_b] <= 1'b1;
                        r_rm_cnt       <= r_rm_cnt + CNT_ONE;
                    end
                    r_j <= r_j + CNT_ONE;
                end
                gbn_pkg::S_E_RD: begin
                    if (r_i >= r_count) begin
                        // Close the set
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_removed  <= '0;
                        r_rm_cnt   <= '0;
                        r_emit_cnt <= '0;
                    end
                end
                gbn_pkg::S_E_WT: begin
                    if (r_removed[r_rank_q]) r_i <= r_i + CNT_ONE;
                end
                gbn_pkg::S_E_BOX: begin
                    r_emit_cnt <= r_emit_cnt + CNT_ONE;
                    r_i        <= r_i + CNT_ONE;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for greedy_box_nms: box sets in, kept boxes checked in order.
// Depends on gbn_pkg and greedy_box_nms; predicts suppression internally.
`default_nettype none
module tb;

    localparam int CAP = 64;
    localparam int DRAIN = 20000;
    localparam int LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    gbn_pkg::t_box_in i_box = '0;
    logic o_strobe;
    gbn_pkg::t_box_out o_kept;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    greedy_box_nms uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_box(i_box),
        .o_strobe(o_strobe), .o_kept(o_kept), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // Stimulus and expectation state
    gbn_pkg::t_box_in pending_boxes[$];
    gbn_pkg::t_box_out kept_expected[$];
    gbn_pkg::t_box_in set_boxes[$];
    logic [15:0] thr_model = gbn_pkg::THR_RESET;
    int overflow_model = 0;
    int idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    bit timed_out = 0;

    function automatic logic [31:0] extent(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? 32'(hi - lo) : 32'd0;
    endfunction

    function automatic logic [31:0] box_area(gbn_pkg::t_box_in b);
        return extent(b.left_x, b.right_x) * extent(b.top_y, b.bottom_y);
    endfunction

    // Return 1 when the later box b overlaps a above the threshold
    function automatic bit suppresses(gbn_pkg::t_box_in a, gbn_pkg::t_box_in b,
                                      logic [15:0] thr);
        logic [15:0] l, t, r, btm;
        logic [63:0] inter, uni;
        l = (a.left_x > b.left_x) ? a.left_x : b.left_x;
        t = (a.top_y > b.top_y) ? a.top_y : b.top_y;
        r = (a.right_x < b.right_x) ? a.right_x : b.right_x;
        btm = (a.bottom_y < b.bottom_y) ? a.bottom_y : b.bottom_y;
        inter = 64'(extent(l, r)) * 64'(extent(t, btm));
        uni = 64'(box_area(a)) + 64'(box_area(b)) - inter;
        return (inter * 64'd32768) > (64'(thr) * uni);
    endfunction

    function automatic gbn_pkg::t_box_out kept_of(gbn_pkg::t_box_in b, bit fin, bit ovf);
        gbn_pkg::t_box_out o;
        o.kept_left_x = b.left_x;
        o.kept_top_y = b.top_y;
        o.kept_right_x = b.right_x;
        o.kept_bottom_y = b.bottom_y;
        o.kept_confidence = b.confidence;
        o.kept_label = b.class_label;
        o.kept_image = b.image_tag;
        o.final_kept = fin;
        o.overflowed = ovf;
        return o;
    endfunction

    // Accept one item into the prediction; close the set on last_box
    task automatic predict_nms(gbn_pkg::t_box_in b);
        int n, i, j, last, cur;
        int order[CAP];
        bit gone[CAP];
        if (set_boxes.size() < CAP) set_boxes = {set_boxes, b};
        else overflow_model = 1;
        if (b.last_box) begin
            n = set_boxes.size();
            if (thr_model == 0) begin
                for (i = 0; i < n; i++)
                    kept_expected = {kept_expected,
                                     kept_of(set_boxes[i], i == n - 1, overflow_model)};
            end else begin
                for (i = 0; i < n; i++) begin
                    cur = i;
                    j = i;
                    while (j > 0 && set_boxes[order[j-1]].confidence < set_boxes[cur].confidence) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = cur;
                    gone[i] = 0;
                end
                for (i = 0; i < n; i++) begin
                    if (gone[order[i]]) continue;
                    for (j = i + 1; j < n; j++)
                        if (!gone[order[j]] &&
                            suppresses(set_boxes[order[i]], set_boxes[order[j]], thr_model))
                            gone[order[j]] = 1;
                end
                last = 0;
                for (i = 0; i < n; i++) if (!gone[order[i]]) last = i;
                for (i = 0; i < n; i++)
                    if (!gone[order[i]])
                        kept_expected = {kept_expected,
                                         kept_of(set_boxes[order[i]], i == last,
                                                 overflow_model)};
            end
            set_boxes.delete();
            overflow_model = 0;
        end
    endtask

    // Driver: present the next item, retire it on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_nms(i_box);
                void'(pending_boxes.pop_front());
            end
            if ((!start || !busy) && pending_boxes.size() > 0
                && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_box <= pending_boxes[0];
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each kept box with the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (kept_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_kept);
            end else begin
                if (o_kept !== kept_expected[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", kept_expected[0], o_kept);
                end
                void'(kept_expected.pop_front());
            end
        end
    end

    task automatic write_threshold(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thr_model = v;
    endtask

    function automatic logic [15:0] coord();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic gbn_pkg::t_box_in rand_box(bit fin);
        gbn_pkg::t_box_in b;
        logic [15:0] x, y;
        x = 16'($urandom_range(30000));
        y = 16'($urandom_range(30000));
        b.left_x = x;
        b.top_y = y;
        b.right_x = x + 16'($urandom_range(2768));
        b.bottom_y = y + 16'($urandom_range(2768));
        if ($urandom_range(9) == 0) begin
            b.left_x = coord(); b.top_y = coord(); b.right_x = coord(); b.bottom_y = coord();
        end
        b.confidence = ($urandom_range(3) == 0) ? 16'($urandom_range(4)) * 16'd8192
                                                : (($urandom_range(9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(32768)));
        b.class_label = 8'($urandom);
        b.image_tag = 8'($urandom);
        b.last_box = fin;
        return b;
    endfunction

    // Queue a set of n boxes, the last one marked; nearby clusters make overlap
    task automatic queue_set(int n);
        gbn_pkg::t_box_in b;
        for (int i = 0; i < n; i++) begin
            b = rand_box(i == n - 1);
            if (i > 0 && $urandom_range(1)) begin
                b.left_x = pending_boxes[$].left_x + 16'($urandom_range(300));
                b.top_y = pending_boxes[$].top_y + 16'($urandom_range(300));
                b.right_x = b.left_x + 16'($urandom_range(3000));
                b.bottom_y = b.top_y + 16'($urandom_range(3000));
            end
            pending_boxes = {pending_boxes, b};
        end
    endtask

    task automatic run_phase();
        while (pending_boxes.size() > 0 || kept_expected.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Timeout guard
    always @(posedge i_clk) begin
        if (cycles > LIMIT && !timed_out) begin
            timed_out = 1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        gbn_pkg::t_box_in b;
        int items;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, identical and degenerate boxes, ties
        b = '0; b.right_x = 16'd32768; b.bottom_y = 16'd32768; b.confidence = 16'd32768;
        b.class_label = 8'hff; b.image_tag = 8'hff;
        pending_boxes = {pending_boxes, b};
        pending_boxes = {pending_boxes, b};
        b = '0; b.left_x = 16'hffff; b.top_y = 16'hffff; b.confidence = 16'hffff;
        pending_boxes = {pending_boxes, b};
        b = '0; b.right_x = 16'd100; b.bottom_y = 16'd100; b.confidence = 16'd5;
        pending_boxes = {pending_boxes, b};
        b.left_x = 16'd50; b.right_x = 16'd150; b.last_box = 1'b1;
        pending_boxes = {pending_boxes, b};
        b = rand_box(1);
        pending_boxes = {pending_boxes, b};
        run_phase();

        // Overflow: a full store plus dropped candidates, the last one too
        queue_set(CAP + 3);
        run_phase();

        items = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_threshold(16'd0);
                1: write_threshold(16'd32768);
                2: write_threshold(16'hffff);
                default: write_threshold(16'($urandom_range(1, 32767)));
            endcase
            if (ph == 7) write_threshold(16'd1);
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 71 : 20);
            while (items < (ph + 1) * 46) begin
                int n;
                n = ($urandom_range(15) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
                queue_set(n);
                items += n;
            end
            run_phase();
        end
        write_threshold(gbn_pkg::THR_RESET);
        queue_set(6);
        run_phase();

        if (mismatches == 0 && kept_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
design/gbn_pkg.sv
design/greedy_box_nms.sv
tb/tb.sv
